[hdl/oae_pkg.sv]
package oae_pkg;

  localparam int IDX_W  = 7;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 8;
  localparam int ST_W   = 2;

  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_INSERT  = 3'd1,
    OP_DELETE  = 3'd2,
    OP_SEARCH  = 3'd3,
    OP_SORT    = 3'd4,
    OP_REVERSE = 3'd5
  } op_t;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] data;
    logic [IDX_W-1:0]  found_index;
    logic [CNT_W-1:0]  count;
  } res_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_t;

endpackage

[hdl/ordered_array_engine.sv]
// Ordered array engine: a packed store of DEPTH signed 32-bit entries with a
// fill count, driven by one operation per item (read, insert, delete, search,
// ascending sort, reverse) and giving exactly one result per item. All work
// runs through one memory with a single registered read port and one write
// port, stepped by a small sequencer with one shared compare unit, so the
// cost of an item, from acceptance until its result is offered, is set by
// memory accesses: insert and delete move each entry past the index by one
// place, search reads entries in order up to the first match, reverse swaps
// pairs from both ends inward, and sort (insertion order) moves each entry
// down past every larger one before it. Invalid positions, a full store and
// unused op codes return with no memory access. in_ready is high whenever
// the sequencer is idle; a finished result waits in the output register, so
// the next item may enter while it is still held. The entry store is not
// cleared at reset; only the count is.
module ordered_array_engine #(
  parameter int DEPTH = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_op,
  input  logic [oae_pkg::IDX_W-1:0]         in_index,
  input  logic signed [oae_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [oae_pkg::ST_W-1:0]          out_status,
  output logic signed [oae_pkg::DATA_W-1:0] out_data,
  output logic [oae_pkg::IDX_W-1:0]         out_found_index,
  output logic [oae_pkg::CNT_W-1:0]         out_count
);
  import oae_pkg::*;

  logic  core_idle;
  logic  core_res_valid;
  logic  load;
  res_t  core_res;
  logic  out_valid_r, out_valid_nxt;
  res_t  out_r, out_nxt;

  assign in_ready = core_idle;
  // result moves into the output register when it is empty or draining
  assign load = core_res_valid && (!out_valid_r || out_ready);

  oae_core #(
    .DEPTH (DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && in_ready),
    .op        (in_op),
    .index     (in_index),
    .value     (in_value),
    .idle      (core_idle),
    .res_valid (core_res_valid),
    .res_take  (load),
    .res       (core_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_nxt       = core_res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_data        = $signed(out_r.data);
  assign out_found_index = out_r.found_index;
  assign out_count       = out_r.count;

endmodule

[hdl/oae_cmp.sv]
// Shared compare unit: equality for search, signed greater-than for the sort.
module oae_cmp (
  input  logic [oae_pkg::DATA_W-1:0] a,
  input  logic [oae_pkg::DATA_W-1:0] b,
  output oae_pkg::cmp_t              flags
);
  import oae_pkg::*;

  assign flags.eq = (a == b);
  assign flags.gt = ($signed(a) > $signed(b));

endmodule

[hdl/oae_core.sv]
module oae_core #(
  parameter int DEPTH = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [2:0]                 op,
  input  logic [oae_pkg::IDX_W-1:0]  index,
  input  logic [oae_pkg::DATA_W-1:0] value,
  output logic                       idle,
  output logic                       res_valid,
  input  logic                       res_take,
  output oae_pkg::res_t              res
);
  import oae_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [4:0] {
    S_IDLE,
    S_READ_WAIT,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_WR,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SORT_KRD,
    S_SORT_KCAP,
    S_SORT_RD,
    S_SORT_CMP,
    S_SORT_PUT,
    S_REV_RDA,
    S_REV_RDB,
    S_REV_WRA,
    S_REV_WRB,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     ptr2_r, ptr2_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [DATA_W-1:0] opnd_r, opnd_nxt;
  logic [DATA_W-1:0] tmp_r, tmp_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [ST_W-1:0]   status_r, status_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [IDX_W-1:0]  found_r, found_nxt;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DATA_W-1:0] mem_wd;
  logic [AW-1:0]     mem_ra;

  logic [XW-1:0]     idx_x;
  logic [XW-1:0]     n_x;
  cmp_t              cmp;

  assign idx_x = XW'(index);
  assign n_x   = XW'(count_r);

  oae_cmp u_cmp (
    .a     (rdata_r),
    .b     (opnd_r),
    .flags (cmp)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  always_comb begin
    state_nxt  = state_r;
    ptr_nxt    = ptr_r;
    ptr2_nxt   = ptr2_r;
    idx_nxt    = idx_r;
    opnd_nxt   = opnd_r;
    tmp_nxt    = tmp_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    data_nxt   = data_r;
    found_nxt  = found_r;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '0;
    mem_ra     = '0;
    unique case (state_r)
      S_IDLE: begin
        // read port looks up the index right away, used by a plain read
        mem_ra = AW'(index);
        if (start) begin
          status_nxt = ST_OK;
          data_nxt   = '0;
          found_nxt  = '0;
          opnd_nxt   = value;
          idx_nxt    = AW'(index);
          unique case (op)
            OP_READ: begin
              if (idx_x < n_x) begin
                state_nxt = S_READ_WAIT;
              end else begin
                status_nxt = ST_INVALID;
                state_nxt  = S_DONE;
              end
            end
            OP_INSERT: begin
              if (idx_x <= n_x && count_r < CW'(DEPTH)) begin
                ptr_nxt   = count_r;
                state_nxt = (idx_x == n_x) ? S_INS_PUT : S_INS_RD;
              end else begin
                status_nxt = ST_INVALID;
                state_nxt  = S_DONE;
              end
            end
            OP_DELETE: begin
              if (idx_x < n_x) begin
                ptr_nxt = CW'(index);
                if (idx_x + XW'(1) < n_x) begin
                  state_nxt = S_DEL_RD;
                end else begin
                  count_nxt = count_r - CW'(1);
                  state_nxt = S_DONE;
                end
              end else begin
                status_nxt = ST_INVALID;
                state_nxt  = S_DONE;
              end
            end
            OP_SEARCH: begin
              status_nxt = ST_NOTFOUND;
              ptr_nxt    = '0;
              state_nxt  = (count_r == '0) ? S_DONE : S_SRCH_RD;
            end
            OP_SORT: begin
              ptr_nxt   = CW'(1);
              state_nxt = (count_r < CW'(2)) ? S_DONE : S_SORT_KRD;
            end
            OP_REVERSE: begin
              ptr_nxt   = '0;
              ptr2_nxt  = count_r - CW'(1);
              state_nxt = (count_r < CW'(2)) ? S_DONE : S_REV_RDA;
            end
            default: begin
              status_nxt = ST_INVALID;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end
      S_READ_WAIT: begin
        data_nxt  = rdata_r;
        state_nxt = S_DONE;
      end
      S_INS_RD: begin
        mem_ra    = AW'(ptr_r - CW'(1));
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        mem_we  = 1'b1;
        mem_wa  = AW'(ptr_r);
        mem_wd  = rdata_r;
        ptr_nxt = ptr_r - CW'(1);
        state_nxt = (ptr_r - CW'(1) == CW'(idx_r)) ? S_INS_PUT : S_INS_RD;
      end
      S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_wa    = idx_r;
        mem_wd    = opnd_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_DEL_RD: begin
        mem_ra    = AW'(ptr_r + CW'(1));
        state_nxt = S_DEL_WR;
      end
      S_DEL_WR: begin
        mem_we  = 1'b1;
        mem_wa  = AW'(ptr_r);
        mem_wd  = rdata_r;
        ptr_nxt = ptr_r + CW'(1);
        // keep going while the next slot still has a successor
        if ((CW+1)'(ptr_r) + (CW+1)'(2) < (CW+1)'(count_r)) begin
          state_nxt = S_DEL_RD;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end
      S_SRCH_RD: begin
        mem_ra    = AW'(ptr_r);
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (cmp.eq) begin
          status_nxt = ST_OK;
          found_nxt  = IDX_W'(ptr_r);
          state_nxt  = S_DONE;
        end else begin
          ptr_nxt   = ptr_r + CW'(1);
          state_nxt = (ptr_r + CW'(1) < count_r) ? S_SRCH_RD : S_DONE;
        end
      end
      S_SORT_KRD: begin
        mem_ra    = AW'(ptr_r);
        state_nxt = S_SORT_KCAP;
      end
      S_SORT_KCAP: begin
        opnd_nxt  = rdata_r;
        ptr2_nxt  = ptr_r;
        state_nxt = S_SORT_RD;
      end
      S_SORT_RD: begin
        mem_ra    = AW'(ptr2_r - CW'(1));
        state_nxt = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        if (cmp.gt) begin
          mem_we    = 1'b1;
          mem_wa    = AW'(ptr2_r);
          mem_wd    = rdata_r;
          ptr2_nxt  = ptr2_r - CW'(1);
          state_nxt = (ptr2_r == CW'(1)) ? S_SORT_PUT : S_SORT_RD;
        end else begin
          state_nxt = S_SORT_PUT;
        end
      end
      S_SORT_PUT: begin
        mem_we    = 1'b1;
        mem_wa    = AW'(ptr2_r);
        mem_wd    = opnd_r;
        ptr_nxt   = ptr_r + CW'(1);
        state_nxt = (ptr_r + CW'(1) < count_r) ? S_SORT_KRD : S_DONE;
      end
      S_REV_RDA: begin
        mem_ra    = AW'(ptr_r);
        state_nxt = S_REV_RDB;
      end
      S_REV_RDB: begin
        tmp_nxt   = rdata_r;
        mem_ra    = AW'(ptr2_r);
        state_nxt = S_REV_WRA;
      end
      S_REV_WRA: begin
        mem_we    = 1'b1;
        mem_wa    = AW'(ptr_r);
        mem_wd    = rdata_r;
        state_nxt = S_REV_WRB;
      end
      S_REV_WRB: begin
        mem_we    = 1'b1;
        mem_wa    = AW'(ptr2_r);
        mem_wd    = tmp_r;
        ptr_nxt   = ptr_r + CW'(1);
        ptr2_nxt  = ptr2_r - CW'(1);
        state_nxt = (ptr_r + CW'(1) < ptr2_r - CW'(1)) ? S_REV_RDA : S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    ptr_r    <= ptr_nxt;
    ptr2_r   <= ptr2_nxt;
    idx_r    <= idx_nxt;
    opnd_r   <= opnd_nxt;
    tmp_r    <= tmp_nxt;
    status_r <= status_nxt;
    data_r   <= data_nxt;
    found_r  <= found_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  assign res.status      = status_r;
  assign res.data        = data_r;
  assign res.found_index = found_r;
  assign res.count       = CNT_W'(count_r);

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import oae_pkg::*;

  localparam int DEPTH = 128;
  localparam int SMALL_FILL = 24;
  localparam int RANDOM_ITEMS = 1300;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT = 2_000_000;

  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  typedef struct {
    logic [2:0]                op;
    logic [IDX_W-1:0]          index;
    logic signed [DATA_W-1:0]  value;
  } array_req_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [2:0]                in_op = '0;
  logic [IDX_W-1:0]          in_index = '0;
  logic signed [DATA_W-1:0]  in_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [ST_W-1:0]           out_status;
  logic signed [DATA_W-1:0]  out_data;
  logic [IDX_W-1:0]          out_found_index;
  logic [CNT_W-1:0]          out_count;

  array_req_t op_queue[$];
  res_t       pending_results[$];
  array_req_t next_req;
  res_t       predicted;
  res_t       oldest;

  // array image kept by the predictor
  logic signed [DATA_W-1:0] shadow_entries [DEPTH];
  int                       shadow_count = 0;

  // fill level as seen while building the stimulus
  int plan_count = 0;

  int total_items = 0;
  int acc_count = 0;
  int result_count = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  ordered_array_engine #(.DEPTH(DEPTH)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_index        (in_index),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_data        (out_data),
    .out_found_index (out_found_index),
    .out_count       (out_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  task automatic apply_array_op(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                                input logic signed [DATA_W-1:0] val, output res_t r);
    int i;
    int j;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] t;
    r = '0;
    case (op)
      OP_READ: begin
        if (idx < shadow_count) r.data = shadow_entries[idx];
        else r.status = ST_INVALID;
      end
      OP_INSERT: begin
        if (idx <= shadow_count && shadow_count < DEPTH) begin
          for (i = shadow_count; i > idx; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[idx] = val;
          shadow_count++;
        end else begin
          r.status = ST_INVALID;
        end
      end
      OP_DELETE: begin
        if (idx < shadow_count) begin
          for (i = idx; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end else begin
          r.status = ST_INVALID;
        end
      end
      OP_SEARCH: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_entries[i] == val) begin
            r.status = ST_OK;
            r.found_index = i[IDX_W-1:0];
            break;
          end
        end
      end
      OP_SORT: begin
        // ascending, signed
        for (i = 1; i < shadow_count; i++) begin
          key = shadow_entries[i];
          j = i;
          while (j > 0 && shadow_entries[j-1] > key) begin
            shadow_entries[j] = shadow_entries[j-1];
            j--;
          end
          shadow_entries[j] = key;
        end
      end
      OP_REVERSE: begin
        for (i = 0; i < shadow_count / 2; i++) begin
          t = shadow_entries[i];
          shadow_entries[i] = shadow_entries[shadow_count-1-i];
          shadow_entries[shadow_count-1-i] = t;
        end
      end
      default: r.status = ST_INVALID;
    endcase
    r.count = shadow_count[CNT_W-1:0];
  endtask

  task automatic push_item(input logic [2:0] op, input logic [IDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] val);
    array_req_t req;
    req.op = op;
    req.index = idx;
    req.value = val;
    op_queue.push_back(req);
    if (op == OP_INSERT && idx <= plan_count && plan_count < DEPTH) plan_count++;
    else if (op == OP_DELETE && idx < plan_count) plan_count--;
  endtask

  // small pool gives duplicates, so searches hit and sorts see ties
  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $signed($urandom_range(15)) - 8;
    if (r < 62) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sh0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // fill to the top, hit the full store, sort a reversed run, then drain
  task automatic fill_and_drain();
    int r;
    while (plan_count < DEPTH)
      push_item(OP_INSERT, IDX_W'($urandom_range(plan_count)), pick_value());
    push_item(OP_INSERT, 7'd0, pick_value());
    push_item(OP_INSERT, 7'd127, pick_value());
    push_item(OP_READ, 7'd127, $urandom);
    push_item(OP_SEARCH, IDX_W'($urandom), pick_value());
    push_item(OP_SORT, IDX_W'($urandom), $urandom);
    push_item(OP_READ, 7'd0, $urandom);
    push_item(OP_READ, 7'd127, $urandom);
    push_item(OP_REVERSE, IDX_W'($urandom), $urandom);
    push_item(OP_SORT, IDX_W'($urandom), $urandom);
    push_item(OP_REVERSE, IDX_W'($urandom), $urandom);
    push_item(OP_SEARCH, IDX_W'($urandom), 32'sh7fff_ffff);
    push_item(OP_DELETE, 7'd127, $urandom);
    while (plan_count > 8) begin
      r = $urandom_range(99);
      if (r < 70) push_item(OP_DELETE, IDX_W'($urandom_range(plan_count - 1)), $urandom);
      else if (r < 85) push_item(OP_READ, IDX_W'($urandom_range(plan_count - 1)), $urandom);
      else push_item(OP_SEARCH, IDX_W'($urandom), pick_value());
    end
  endtask

  function automatic int idle_pct(input bit sender);
    int ph;
    ph = (acc_count * 3 < total_items) ? 0 : (acc_count * 3 < 2 * total_items) ? 1 : 2;
    if (sender) return (ph == 0) ? 17 : (ph == 1) ? 63 : 0;
    return (ph == 0) ? 63 : (ph == 1) ? 17 : 0;
  endfunction

  // stimulus build and end of run
  initial begin
    int r;
    int deep_runs;
    logic [2:0] op;
    deep_runs = 0;

    // empty store
    push_item(OP_READ, 7'd0, 32'sd0);
    push_item(OP_DELETE, 7'd0, 32'sd0);
    push_item(OP_SEARCH, 7'd0, 32'sd0);
    push_item(OP_SORT, 7'd0, 32'sd0);
    push_item(OP_REVERSE, 7'd127, -32'sd1);
    push_item(OP_INSERT, 7'd1, 32'sd9);
    // single entry
    push_item(OP_INSERT, 7'd0, 32'sh7fff_ffff);
    push_item(OP_SORT, 7'd0, 32'sd0);
    push_item(OP_REVERSE, 7'd0, 32'sd0);
    // append, middle, front
    push_item(OP_INSERT, 7'd1, 32'sh8000_0000);
    push_item(OP_INSERT, 7'd1, -32'sd1);
    push_item(OP_INSERT, 7'd0, 32'sd5);
    push_item(OP_READ, 7'd0, 32'sd0);
    push_item(OP_READ, 7'd3, 32'sd0);
    push_item(OP_READ, 7'd4, 32'sd0);
    push_item(OP_READ, 7'd127, 32'sd0);
    push_item(OP_INSERT, 7'd6, 32'sd1);
    push_item(OP_SEARCH, 7'd0, -32'sd1);
    push_item(OP_SEARCH, 7'd0, 32'sd1234);
    // duplicate: search returns the first match
    push_item(OP_INSERT, 7'd4, 32'sd5);
    push_item(OP_SEARCH, 7'd0, 32'sd5);
    push_item(OP_SORT, 7'd0, 32'sd0);
    push_item(OP_REVERSE, 7'd0, 32'sd0);
    push_item(OP_DELETE, 7'd1, 32'sd0);
    push_item(OP_DELETE, 7'd4, 32'sd0);
    push_item(OP_UNUSED_6, 7'd0, 32'sd0);
    push_item(OP_UNUSED_7, 7'd127, -32'sd1);

    while (op_queue.size() < RANDOM_ITEMS) begin
      if ((deep_runs == 0 && op_queue.size() >= 300) ||
          (deep_runs == 1 && op_queue.size() >= 850)) begin
        fill_and_drain();
        deep_runs++;
      end else if ($urandom_range(99) < 15) begin
        push_item(3'($urandom_range(7)), IDX_W'($urandom_range(127)), $urandom);
      end else if (plan_count == 0) begin
        push_item(OP_INSERT, 7'd0, pick_value());
      end else begin
        r = $urandom_range(99);
        if (r < 30) op = OP_INSERT;
        else if (r < 52) op = OP_DELETE;
        else if (r < 72) op = OP_READ;
        else if (r < 86) op = OP_SEARCH;
        else if (r < 93) op = OP_SORT;
        else op = OP_REVERSE;
        // keep the fill level low so sorts stay short
        if (op == OP_INSERT && plan_count >= SMALL_FILL) op = OP_DELETE;
        case (op)
          OP_INSERT: push_item(op, IDX_W'($urandom_range(plan_count)), pick_value());
          OP_DELETE, OP_READ:
            push_item(op, IDX_W'($urandom_range(plan_count - 1)), $urandom);
          OP_SEARCH: push_item(op, IDX_W'($urandom), pick_value());
          default: push_item(op, IDX_W'($urandom), $urandom);
        endcase
      end
    end
    total_items = op_queue.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (!(acc_count == total_items && pending_results.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (op_queue.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
        next_req = op_queue.pop_front();
        in_valid <= 1'b1;
        in_op    <= next_req.op;
        in_index <= next_req.index;
        in_value <= next_req.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check the result first, then predict the item taken this edge
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no item pending", result_count));
        end else begin
          oldest = pending_results.pop_front();
          if (out_status !== oldest.status)
            report_mismatch($sformatf("result %0d status got %0d want %0d",
                                      result_count, out_status, oldest.status));
          if (out_data !== oldest.data)
            report_mismatch($sformatf("result %0d data got %h want %h",
                                      result_count, out_data, oldest.data));
          if (out_found_index !== oldest.found_index)
            report_mismatch($sformatf("result %0d found_index got %0d want %0d",
                                      result_count, out_found_index, oldest.found_index));
          if (out_count !== oldest.count)
            report_mismatch($sformatf("result %0d count got %0d want %0d",
                                      result_count, out_count, oldest.count));
        end
        result_count <= result_count + 1;
      end
      if (in_valid && in_ready) begin
        apply_array_op(in_op, in_index, in_value, predicted);
        pending_results.push_back(predicted);
        acc_count <= acc_count + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

[filelist.f]
hdl/oae_pkg.sv
hdl/oae_cmp.sv
hdl/oae_core.sv
hdl/ordered_array_engine.sv
tb/sv/tb_top.sv
